### hdl/assert_macros.svh
// Assertion macros shared by the recolor block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define HPR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define HPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);
`else
`define HPR_ASSERT(lbl, prop, msg)
`define HPR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### hdl/hpr_pkg.sv
// Types, constants and stage payloads of the HSV pixel recolor block.
package hpr_pkg;

  localparam int HUE_STEPS = 360;

  localparam int HUE_W = 9;
  localparam int SAT_W = 16;
  localparam int CH_W  = 8;
  localparam int CFG_W = 16;
  localparam int IDX_W = 2;
  localparam int Q_W   = 16;
  localparam int ONE_W = Q_W + 1;
  localparam int NSTG  = 7;

  localparam int H6_W    = $clog2(6 * HUE_STEPS);
  localparam int NUM_W   = $clog2(HUE_STEPS + 1);
  localparam int TRCP_SH = NUM_W + Q_W;
  localparam int TRCP_W  = TRCP_SH - $clog2(HUE_STEPS) + 1;

  localparam int VQ_SH   = 14;
  localparam int VDIV    = 255;
  localparam int VDIV_SH = CH_W + VQ_SH;
  localparam int VRCP_W  = VDIV_SH - $clog2(VDIV) + 1;

  typedef logic [HUE_W-1:0]            hue_t;
  typedef logic [SAT_W-1:0]            sat_t;
  typedef logic [CH_W-1:0]             ch_t;
  typedef logic [CFG_W-1:0]            cfg_t;
  typedef logic [IDX_W-1:0]            idx_t;
  typedef logic [ONE_W-1:0]            one_t;
  typedef logic [H6_W-1:0]             h6_t;
  typedef logic [NUM_W-1:0]            num_t;
  typedef logic [2:0]                  sec_t;
  typedef logic [TRCP_W-1:0]           trcp_t;
  typedef logic [NUM_W+TRCP_W-1:0]     tp_t;
  typedef logic [NUM_W+ONE_W-1:0]      rm_t;
  typedef logic [VRCP_W-1:0]           vq_t;
  typedef logic [CH_W+VRCP_W-1:0]      vp_t;
  typedef logic [CH_W+VQ_SH-1:0]       vx_t;
  typedef logic [ONE_W+SAT_W-1:0]      cp_t;
  typedef logic [2*ONE_W-1:0]          xp_t;
  typedef logic [CH_W+ONE_W-1:0]       op_t;
  typedef logic [NSTG-1:0]             stg_t;

  localparam h6_t   STEPS_H6 = h6_t'(HUE_STEPS);
  localparam rm_t   STEPS_RM = rm_t'(HUE_STEPS);
  localparam trcp_t TRCP     = trcp_t'((64'd1 << TRCP_SH) / HUE_STEPS);
  localparam vq_t   VRCP     = vq_t'((64'd1 << VDIV_SH) / VDIV);
  localparam vx_t   VDIV_VX  = vx_t'(VDIV);
  localparam one_t  VHALF    = one_t'(32768);
  localparam one_t  VONE     = one_t'(65536);
  localparam ch_t   CH_MAX   = ch_t'(255);

  localparam idx_t REG_HUE      = idx_t'(0);
  localparam idx_t REG_TILE_SAT = idx_t'(1);
  localparam idx_t REG_TINT_SAT = idx_t'(2);

  localparam hue_t HUE_RST      = hue_t'(0);
  localparam sat_t TILE_SAT_RST = sat_t'(13107);
  localparam sat_t TINT_SAT_RST = sat_t'(6554);

  // Hue sectors, named by the red, green and blue terms (C chroma, X ramp, 0 zero).
  localparam sec_t SEC_CX0 = sec_t'(0);
  localparam sec_t SEC_XC0 = sec_t'(1);
  localparam sec_t SEC_0CX = sec_t'(2);
  localparam sec_t SEC_0XC = sec_t'(3);
  localparam sec_t SEC_X0C = sec_t'(4);
  localparam sec_t SEC_C0X = sec_t'(5);

  typedef struct packed {
    logic            func;
    logic [2:0][CH_W-1:0] ch;
    ch_t             alpha;
    ch_t             maxc;
    sec_t            sector;
    num_t            num;
    sat_t            sat;
  } prep_t;

  typedef struct packed {
    logic            func;
    logic [2:0][CH_W-1:0] ch;
    ch_t             alpha;
    sec_t            sector;
    sat_t            sat;
    one_t            v;
    one_t            t;
  } scale_t;

  typedef struct packed {
    logic            func;
    logic [2:0][CH_W-1:0] ch;
    ch_t             alpha;
    logic [2:0][ONE_W-1:0] frac;
  } frac_t;

endpackage

### hdl/hpr_prep.sv
// First stage: channel inversion, maximum channel and hue sector split.
module hpr_prep (
  input  logic           clk,
  input  logic           en,
  input  logic           func,
  input  logic           invert,
  input  hpr_pkg::ch_t   red,
  input  hpr_pkg::ch_t   green,
  input  hpr_pkg::ch_t   blue,
  input  hpr_pkg::ch_t   alpha,
  input  hpr_pkg::hue_t  hue,
  input  hpr_pkg::sat_t  tile_sat,
  input  hpr_pkg::sat_t  tint_sat,
  output hpr_pkg::prep_t q_r
);

  logic [2:0][hpr_pkg::CH_W-1:0] ch;
  logic [2:0][hpr_pkg::CH_W-1:0] tch;
  hpr_pkg::ch_t   maxc;
  hpr_pkg::h6_t   hx;
  hpr_pkg::h6_t   h6;
  hpr_pkg::h6_t   base;
  hpr_pkg::h6_t   r6;
  hpr_pkg::h6_t   d;
  hpr_pkg::sec_t  sector;
  hpr_pkg::prep_t q_nxt;

  always_comb begin
    ch = {blue, green, red};
    for (int i = 0; i < 3; i++) begin
      tch[i] = (invert && !func) ? ~ch[i] : ch[i];
    end
    maxc = tch[0];
    if (tch[1] > maxc) begin
      maxc = tch[1];
    end
    if (tch[2] > maxc) begin
      maxc = tch[2];
    end

    hx = hpr_pkg::h6_t'(hue);
    if (hx >= hpr_pkg::STEPS_H6) begin
      hx = hx - hpr_pkg::STEPS_H6;
    end
    h6 = (hx << 2) + (hx << 1);

    sector = hpr_pkg::SEC_CX0;
    for (int k = 1; k < 6; k++) begin
      if (h6 >= hpr_pkg::h6_t'(k * hpr_pkg::HUE_STEPS)) begin
        sector = hpr_pkg::sec_t'(k);
      end
    end

    if (sector >= hpr_pkg::SEC_X0C) begin
      base = hpr_pkg::STEPS_H6 << 2;
    end else if (sector >= hpr_pkg::SEC_0CX) begin
      base = hpr_pkg::STEPS_H6 << 1;
    end else begin
      base = '0;
    end
    r6 = h6 - base;
    d  = (r6 >= hpr_pkg::STEPS_H6) ? r6 - hpr_pkg::STEPS_H6 : hpr_pkg::STEPS_H6 - r6;

    q_nxt.func   = func;
    q_nxt.ch     = ch;
    q_nxt.alpha  = alpha;
    q_nxt.maxc   = maxc;
    q_nxt.sector = sector;
    q_nxt.num    = hpr_pkg::num_t'(hpr_pkg::STEPS_H6 - d);
    q_nxt.sat    = func ? tint_sat : tile_sat;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end

endmodule

### hdl/hpr_scale.sv
// Second and third stages: hue ramp and tile value by reciprocal division.
module hpr_scale (
  input  logic            clk,
  input  logic            en_mul,
  input  logic            en_fix,
  input  hpr_pkg::prep_t  d,
  output hpr_pkg::scale_t q_r
);

  hpr_pkg::prep_t  p_r;
  hpr_pkg::tp_t    tprod_r;
  hpr_pkg::vp_t    vprod_r;

  hpr_pkg::one_t   t_est;
  hpr_pkg::one_t   t_fix;
  hpr_pkg::rm_t    t_rem;
  hpr_pkg::vq_t    q_est;
  hpr_pkg::vq_t    q_fix;
  hpr_pkg::vx_t    v_rem;
  hpr_pkg::one_t   v;
  hpr_pkg::scale_t q_nxt;

  always_ff @(posedge clk) begin
    if (en_mul) begin
      p_r     <= d;
      tprod_r <= hpr_pkg::tp_t'(d.num) * hpr_pkg::tp_t'(hpr_pkg::TRCP);
      vprod_r <= hpr_pkg::vp_t'(d.maxc) * hpr_pkg::vp_t'(hpr_pkg::VRCP);
    end
  end

  // The reciprocal products come out at most one below the true quotient.
  always_comb begin
    t_est = tprod_r[hpr_pkg::NUM_W +: hpr_pkg::ONE_W];
    t_rem = hpr_pkg::rm_t'({p_r.num, {hpr_pkg::Q_W{1'b0}}})
          - hpr_pkg::rm_t'(t_est) * hpr_pkg::STEPS_RM;
    t_fix = (t_rem >= hpr_pkg::STEPS_RM) ? t_est + hpr_pkg::one_t'(1) : t_est;

    q_est = vprod_r[hpr_pkg::VDIV_SH - hpr_pkg::VQ_SH +: hpr_pkg::VRCP_W];
    v_rem = {p_r.maxc, {hpr_pkg::VQ_SH{1'b0}}} - hpr_pkg::vx_t'(q_est) * hpr_pkg::VDIV_VX;
    q_fix = (v_rem >= hpr_pkg::VDIV_VX) ? q_est + hpr_pkg::vq_t'(1) : q_est;
    v     = p_r.func ? hpr_pkg::VONE : hpr_pkg::VHALF + hpr_pkg::one_t'(q_fix);

    q_nxt.func   = p_r.func;
    q_nxt.ch     = p_r.ch;
    q_nxt.alpha  = p_r.alpha;
    q_nxt.sector = p_r.sector;
    q_nxt.sat    = p_r.sat;
    q_nxt.v      = v;
    q_nxt.t      = t_fix;
  end

  always_ff @(posedge clk) begin
    if (en_fix) begin
      q_r <= q_nxt;
    end
  end

endmodule

### hdl/hpr_hsv.sv
// Fourth to sixth stages: chroma, ramp term, offset and per-sector channel fractions.
module hpr_hsv (
  input  logic            clk,
  input  logic            en_c,
  input  logic            en_x,
  input  logic            en_f,
  input  hpr_pkg::scale_t d,
  output hpr_pkg::frac_t  q_r
);

  hpr_pkg::scale_t s1_r;
  hpr_pkg::one_t   chroma_r;
  hpr_pkg::scale_t s2_r;
  hpr_pkg::one_t   c2_r;
  hpr_pkg::one_t   x_r;
  hpr_pkg::one_t   m_r;

  hpr_pkg::cp_t    cprod;
  hpr_pkg::xp_t    xprod;
  hpr_pkg::one_t   rv;
  hpr_pkg::one_t   gv;
  hpr_pkg::one_t   bv;
  hpr_pkg::frac_t  q_nxt;

  assign cprod = hpr_pkg::cp_t'(d.v) * hpr_pkg::cp_t'(d.sat);
  assign xprod = hpr_pkg::xp_t'(chroma_r) * hpr_pkg::xp_t'(s1_r.t);

  always_ff @(posedge clk) begin
    if (en_c) begin
      s1_r     <= d;
      chroma_r <= cprod[hpr_pkg::Q_W +: hpr_pkg::ONE_W];
    end
    if (en_x) begin
      s2_r <= s1_r;
      c2_r <= chroma_r;
      x_r  <= xprod[hpr_pkg::Q_W +: hpr_pkg::ONE_W];
      m_r  <= s1_r.v - chroma_r;
    end
  end

  always_comb begin
    unique case (s2_r.sector)
      hpr_pkg::SEC_CX0: begin rv = c2_r; gv = x_r;  bv = '0;   end
      hpr_pkg::SEC_XC0: begin rv = x_r;  gv = c2_r; bv = '0;   end
      hpr_pkg::SEC_0CX: begin rv = '0;   gv = c2_r; bv = x_r;  end
      hpr_pkg::SEC_0XC: begin rv = '0;   gv = x_r;  bv = c2_r; end
      hpr_pkg::SEC_X0C: begin rv = x_r;  gv = '0;   bv = c2_r; end
      default:          begin rv = c2_r; gv = '0;   bv = x_r;  end
    endcase
    q_nxt.func    = s2_r.func;
    q_nxt.ch      = s2_r.ch;
    q_nxt.alpha   = s2_r.alpha;
    q_nxt.frac[0] = rv + m_r;
    q_nxt.frac[1] = gv + m_r;
    q_nxt.frac[2] = bv + m_r;
  end

  always_ff @(posedge clk) begin
    if (en_f) begin
      q_r <= q_nxt;
    end
  end

endmodule

### hdl/hpr_out.sv
// Last stage: scales each fraction to a channel and holds the result item.
module hpr_out (
  input  logic           clk,
  input  logic           en,
  input  hpr_pkg::frac_t d,
  output hpr_pkg::ch_t   red,
  output hpr_pkg::ch_t   green,
  output hpr_pkg::ch_t   blue,
  output hpr_pkg::ch_t   alpha
);

  logic [2:0][hpr_pkg::CH_W-1:0] res_r;
  logic [2:0][hpr_pkg::CH_W-1:0] res_nxt;
  hpr_pkg::ch_t                  alpha_r;
  hpr_pkg::ch_t                  alpha_nxt;
  hpr_pkg::ch_t                  mul_a;
  hpr_pkg::op_t                  prod;
  logic [hpr_pkg::CH_W:0]        scaled;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mul_a      = d.func ? d.ch[i] : hpr_pkg::CH_MAX;
      prod       = hpr_pkg::op_t'(mul_a) * hpr_pkg::op_t'(d.frac[i]);
      scaled     = prod[hpr_pkg::Q_W +: hpr_pkg::CH_W + 1];
      res_nxt[i] = scaled[hpr_pkg::CH_W] ? hpr_pkg::CH_MAX : scaled[hpr_pkg::CH_W-1:0];
    end
    alpha_nxt = d.func ? d.alpha : '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r   <= res_nxt;
      alpha_r <= alpha_nxt;
    end
  end

  assign red   = res_r[0];
  assign green = res_r[1];
  assign blue  = res_r[2];
  assign alpha = alpha_r;

endmodule

### hdl/hsv_pixel_recolor.sv
// Top level of the HSV pixel recolor block: configuration registers and pipeline control.
// The block takes one pixel item per clock cycle while in_ready is high and presents its
// result on the out_ ports once it has passed the seven stage registers, which carry a
// valid bit each; a stage loads whenever it is empty or the stage after it moves, so
// bubbles close up and in_ready drops only when all seven stages are full and out_ready
// is low. Configuration writes take effect on items accepted from the next cycle on and
// are meant to be made while no item is in flight. There is no start-up pass after reset.
`include "assert_macros.svh"

module hsv_pixel_recolor (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          in_func,
  input  logic          in_invert,
  input  hpr_pkg::ch_t  in_red,
  input  hpr_pkg::ch_t  in_green,
  input  hpr_pkg::ch_t  in_blue,
  input  hpr_pkg::ch_t  in_alpha,
  output logic          out_valid,
  input  logic          out_ready,
  output hpr_pkg::ch_t  out_red,
  output hpr_pkg::ch_t  out_green,
  output hpr_pkg::ch_t  out_blue,
  output hpr_pkg::ch_t  out_alpha,
  input  logic          cfg_we,
  input  hpr_pkg::idx_t cfg_index,
  input  hpr_pkg::cfg_t cfg_wdata
);

  hpr_pkg::hue_t   hue_r;
  hpr_pkg::sat_t   tile_sat_r;
  hpr_pkg::sat_t   tint_sat_r;
  hpr_pkg::stg_t   vld_r;
  hpr_pkg::stg_t   vld_nxt;
  hpr_pkg::stg_t   stg_en;
  hpr_pkg::prep_t  prep;
  hpr_pkg::scale_t scaled;
  hpr_pkg::frac_t  frac;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hue_r      <= hpr_pkg::HUE_RST;
      tile_sat_r <= hpr_pkg::TILE_SAT_RST;
      tint_sat_r <= hpr_pkg::TINT_SAT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hpr_pkg::REG_HUE:      hue_r      <= cfg_wdata[hpr_pkg::HUE_W-1:0];
        hpr_pkg::REG_TILE_SAT: tile_sat_r <= cfg_wdata[hpr_pkg::SAT_W-1:0];
        hpr_pkg::REG_TINT_SAT: tint_sat_r <= cfg_wdata[hpr_pkg::SAT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    stg_en[hpr_pkg::NSTG-1] = !vld_r[hpr_pkg::NSTG-1] || out_ready;
    for (int k = hpr_pkg::NSTG - 2; k >= 0; k--) begin
      stg_en[k] = !vld_r[k] || stg_en[k+1];
    end
    vld_nxt[0] = stg_en[0] ? in_valid : vld_r[0];
    for (int k = 1; k < hpr_pkg::NSTG; k++) begin
      vld_nxt[k] = stg_en[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready  = stg_en[0];
  assign out_valid = vld_r[hpr_pkg::NSTG-1];

  hpr_prep u_prep (
    .clk      (clk),
    .en       (stg_en[0]),
    .func     (in_func),
    .invert   (in_invert),
    .red      (in_red),
    .green    (in_green),
    .blue     (in_blue),
    .alpha    (in_alpha),
    .hue      (hue_r),
    .tile_sat (tile_sat_r),
    .tint_sat (tint_sat_r),
    .q_r      (prep)
  );

  hpr_scale u_scale (
    .clk    (clk),
    .en_mul (stg_en[1]),
    .en_fix (stg_en[2]),
    .d      (prep),
    .q_r    (scaled)
  );

  hpr_hsv u_hsv (
    .clk  (clk),
    .en_c (stg_en[3]),
    .en_x (stg_en[4]),
    .en_f (stg_en[5]),
    .d    (scaled),
    .q_r  (frac)
  );

  hpr_out u_out (
    .clk   (clk),
    .en    (stg_en[6]),
    .d     (frac),
    .red   (out_red),
    .green (out_green),
    .blue  (out_blue),
    .alpha (out_alpha)
  );

  `HPR_ASSERT(a_bubble_ready, !(&vld_r) |-> in_ready, "pipeline has a bubble but stalls input")
  `HPR_ASSERT(a_stall_full, !in_ready |-> out_valid && !out_ready, "input stalled without output stall")
  `HPR_ASSERT_NEXT(a_accept_enters, in_valid && in_ready, vld_r[0], "accepted item not in first stage")
  `HPR_ASSERT_NEXT(a_drain, out_valid && out_ready && !vld_r[hpr_pkg::NSTG-2], !out_valid, "result repeated")

endmodule
